FILE: src/window_occlusion_culler_macros.svh
// assertion macros for the window occlusion culler
// used by src/window_occlusion_culler.sv, no other dependencies
`ifndef WINDOW_OCCLUSION_CULLER_MACROS_SVH
`define WINDOW_OCCLUSION_CULLER_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define WOC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("window_occlusion_culler: assertion failed");

// condition must never be seen outside reset
`define WOC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("window_occlusion_culler: forbidden condition seen");

`else

`define WOC_ASSERT(lbl, clk, rst_n, prop)
`define WOC_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

FILE: src/woc_pkg.sv
// shared types and constants of the window occlusion culler
// no dependencies; used by window_occlusion_culler
`default_nettype none

package woc_pkg;

    // coverage store depth default
    localparam int COVERAGE_DEPTH = 16;

    // field widths
    localparam int POS_W   = 16;
    localparam int SIZE_W  = 15;
    localparam int ALPHA_W = 8;
    // clipped edges: a right or bottom edge reaches 65534, so 18 bits signed
    localparam int COORD_W = 18;

    localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_Y      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_HEIGHT = 2'd3;

    // configuration reset values
    localparam logic signed [POS_W-1:0] AREA_X_RST      = 16'sd0;
    localparam logic signed [POS_W-1:0] AREA_Y_RST      = 16'sd0;
    localparam logic [SIZE_W-1:0]       AREA_WIDTH_RST  = 15'd1920;
    localparam logic [SIZE_W-1:0]       AREA_HEIGHT_RST = 15'd1080;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] bottom;
    } t_rect;

    // true when outer fully contains inner (equal edges count as contained)
    function automatic logic rect_holds(input t_rect outer, input t_rect inner);
        return (inner.left >= outer.left) && (inner.right <= outer.right) &&
               (inner.top >= outer.top) && (inner.bottom <= outer.bottom);
    endfunction

endpackage

`default_nettype wire

FILE: src/window_occlusion_culler.sv
// window occlusion culler: view area clip plus coverage store scan
// depends on woc_pkg and window_occlusion_culler_macros.svh
//
// Windows come in from topmost to bottom on the input channel (i_valid /
// o_ready); one occluded flag per window leaves on the output channel
// (o_valid / i_ready). The view area is set through the write port
// (i_cfg_we, i_cfg_idx, i_cfg_data); the user must write it only while
// the block is idle, which the block itself does not enforce.
// An item is taken only in the idle state and clipped; the clip is then
// checked for an empty result, then the store is read one entry per cycle
// through its synchronous read port, stopping at the first entry that
// contains the clip. The done state writes the clip back into the store
// if the window is opaque, not yet contained and the store has room, and
// loads the result register. The scan reads at most n entries, n being
// the number of rectangles in the store (at most COVERAGE_DEPTH);
// transformed and empty windows skip the scan.
// If the receiver stalls, the done state holds until the result register
// is free, and the input stalls behind it. Reset clears the view area to
// 0, 0, 1920 by 1080, empties the store and leaves no result pending;
// frame_start empties the store at the transfer.
`default_nettype none
`include "window_occlusion_culler_macros.svh"

module window_occlusion_culler #(
    parameter int COVERAGE_DEPTH = woc_pkg::COVERAGE_DEPTH
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration write port
    input  wire logic                                  i_cfg_we,
    input  wire logic [woc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [woc_pkg::POS_W-1:0]             i_cfg_data,
    // window input channel
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic                                  i_frame_start,
    input  wire logic signed [woc_pkg::POS_W-1:0]      i_window_x,
    input  wire logic signed [woc_pkg::POS_W-1:0]      i_window_y,
    input  wire logic [woc_pkg::SIZE_W-1:0]            i_window_width,
    input  wire logic [woc_pkg::SIZE_W-1:0]            i_window_height,
    input  wire logic                                  i_transformed,
    input  wire logic [woc_pkg::ALPHA_W-1:0]           i_alpha_level,
    input  wire logic                                  i_shaped,
    // result channel
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic                                       o_occluded
);

    localparam int CNT_W = $clog2(COVERAGE_DEPTH + 1);
    localparam int IDX_W = (COVERAGE_DEPTH > 1) ? $clog2(COVERAGE_DEPTH) : 1;
    localparam int PW    = woc_pkg::POS_W;
    localparam int CW    = woc_pkg::COORD_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // configuration
    logic signed [PW-1:0]              r_area_x;
    logic signed [PW-1:0]              r_area_y;
    logic [woc_pkg::SIZE_W-1:0]        r_area_w;
    logic [woc_pkg::SIZE_W-1:0]        r_area_h;

    // control
    t_state                            r_state;
    t_state                            n_state;
    logic [CNT_W-1:0]                  r_count;
    logic [CNT_W-1:0]                  r_rd_idx;
    logic                              r_rd_vld;
    logic                              r_hit;
    logic                              r_app;
    logic                              r_out_vld;

    // item payload
    woc_pkg::t_rect                    r_clip;
    logic                              r_xform;
    logic                              r_opaque;
    logic                              r_occ;

    // coverage store
    woc_pkg::t_rect                    r_mem [COVERAGE_DEPTH];
    woc_pkg::t_rect                    r_rd_data;

    logic                              w_in_xfer;
    logic                              w_out_xfer;
    logic                              w_out_load;
    logic                              w_issue;
    logic                              w_hit_now;
    logic                              w_empty;
    logic                              w_mem_we;
    logic                              w_room;
    woc_pkg::t_rect                    w_clip;
    logic signed [CW-1:0]              w_wx;
    logic signed [CW-1:0]              w_wy;
    logic signed [CW-1:0]              w_ax;
    logic signed [CW-1:0]              w_ay;
    logic signed [CW-1:0]              w_wr;
    logic signed [CW-1:0]              w_wb;
    logic signed [CW-1:0]              w_ar;
    logic signed [CW-1:0]              w_ab;

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_out_vld;
    assign o_occluded = r_occ;

    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_xfer = r_out_vld && i_ready;
    assign w_out_load = (r_state == S_DONE) && (!r_out_vld || i_ready);
    assign w_room     = (r_count < CNT_W'(COVERAGE_DEPTH));
    assign w_mem_we   = w_out_load && r_app && !r_hit && w_room;

    // clip edges, all at 18 bits so nothing wraps
    always_comb begin
        w_wx = {{(CW-PW){i_window_x[PW-1]}}, i_window_x};
        w_wy = {{(CW-PW){i_window_y[PW-1]}}, i_window_y};
        w_ax = {{(CW-PW){r_area_x[PW-1]}}, r_area_x};
        w_ay = {{(CW-PW){r_area_y[PW-1]}}, r_area_y};
        w_wr = w_wx + $signed({{(CW-woc_pkg::SIZE_W){1'b0}}, i_window_width});
        w_wb = w_wy + $signed({{(CW-woc_pkg::SIZE_W){1'b0}}, i_window_height});
        w_ar = w_ax + $signed({{(CW-woc_pkg::SIZE_W){1'b0}}, r_area_w});
        w_ab = w_ay + $signed({{(CW-woc_pkg::SIZE_W){1'b0}}, r_area_h});
        w_clip.left   = (w_wx > w_ax) ? w_wx : w_ax;
        w_clip.top    = (w_wy > w_ay) ? w_wy : w_ay;
        w_clip.right  = (w_wr < w_ar) ? w_wr : w_ar;
        w_clip.bottom = (w_wb < w_ab) ? w_wb : w_ab;
    end

    assign w_empty = !((r_clip.left < r_clip.right) && (r_clip.top < r_clip.bottom));

    // scan: one read issued per cycle, compared the cycle after
    assign w_hit_now = r_rd_vld && woc_pkg::rect_holds(r_rd_data, r_clip);
    assign w_issue   = (r_state == S_SCAN) && (r_rd_idx < r_count) &&
                       !r_hit && !w_hit_now;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_xform || w_empty) n_state = S_DONE;
                else n_state = S_SCAN;
            end
            S_SCAN: begin
                if (!w_issue) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_x <= woc_pkg::AREA_X_RST;
            r_area_y <= woc_pkg::AREA_Y_RST;
            r_area_w <= woc_pkg::AREA_WIDTH_RST;
            r_area_h <= woc_pkg::AREA_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                woc_pkg::CFG_AREA_X:      r_area_x <= $signed(i_cfg_data);
                woc_pkg::CFG_AREA_Y:      r_area_y <= $signed(i_cfg_data);
                woc_pkg::CFG_AREA_WIDTH:  r_area_w <= i_cfg_data[woc_pkg::SIZE_W-1:0];
                woc_pkg::CFG_AREA_HEIGHT: r_area_h <= i_cfg_data[woc_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_rd_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_app     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_issue;
            if (w_issue) r_rd_idx <= r_rd_idx + CNT_W'(1);

            if (w_in_xfer && i_frame_start) r_count <= '0;
            else if (w_mem_we) r_count <= r_count + CNT_W'(1);

            case (r_state)
                S_CHECK: begin
                    // transformed: never occluded; empty clip: always occluded
                    r_hit    <= !r_xform && w_empty;
                    r_app    <= !r_xform && !w_empty && r_opaque;
                    r_rd_idx <= '0;
                end
                S_SCAN: begin
                    if (w_hit_now) r_hit <= 1'b1;
                end
                default: ;
            endcase

            if (w_out_load) r_out_vld <= 1'b1;
            else if (w_out_xfer) r_out_vld <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_clip   <= w_clip;
            r_xform  <= i_transformed;
            r_opaque <= (i_alpha_level == woc_pkg::ALPHA_OPAQUE) && !i_shaped;
        end
        if (w_out_load) r_occ <= r_hit;
    end

    // coverage store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[r_count[IDX_W-1:0]] <= r_clip;
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) r_rd_data <= r_mem[r_rd_idx[IDX_W-1:0]];
    end

    `WOC_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(COVERAGE_DEPTH))
    `WOC_ASSERT(a_write_has_room, i_clk, i_rst_n, w_mem_we |-> w_room && !r_hit)
    `WOC_ASSERT(a_read_in_range, i_clk, i_rst_n, w_issue |-> r_rd_idx < r_count)
    `WOC_ASSERT(a_hit_ends_scan, i_clk, i_rst_n, (r_state == S_SCAN) && w_hit_now |=> r_state == S_DONE)
    `WOC_ASSERT_NEVER(a_no_write_while_reading, i_clk, i_rst_n, w_mem_we && (w_issue || r_rd_vld))

endmodule

`default_nettype wire
